// ===== rtl/cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg: shared types for the clock multiplier/shift calculator
// Transaction payloads and sequencer state encoding.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ShiftW = 6;
    localparam int unsigned DvdW   = 2 * WordW;
    localparam int unsigned CntW   = 6;   // counts the DvdW division steps

    typedef struct packed {
        logic [WordW-1:0] from_hz;
        logic [WordW-1:0] to_hz;
        logic [WordW-1:0] max_seconds;
    } cms_in_t;

    typedef struct packed {
        logic [WordW-1:0]  mult;
        logic [ShiftW-1:0] shift;
        logic              bad_input;
    } cms_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOM,
        ST_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_OUT
    } cms_state_t;

endpackage

// ===== rtl/clock_mult_shift_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_mult_shift_calc: multiplier/shift pair search for rate conversion
// Finds mult and shift so that (ticks * mult) >> shift converts from_hz
// ticks into to_hz units without overflow over max_seconds.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                      | Payload
//  --------+----------------------------+----------------------------------
//  input   | s_valid, s_ready, s_data   | cms_in_t  {from_hz, to_hz, max_seconds}
//  result  | m_valid, m_ready, m_data   | cms_out_t {mult, shift, bad_input}
//
//  Sequencing: one transaction at a time. After acceptance: the multiply,
//  a headroom search that shifts out the upper word of span*from (up to 32 bits),
//  then per trial shift a load, 64 restoring divide steps and a check,
//  for 1 to START_SHIFT trials, then the hand-over of the result.
//  A zero from_hz skips straight to the result.
//  Reset: synchronous, active low; clears sequencer and m_valid only.
//  Stalls: the result sits in an output register, so a new transaction is
//  accepted while the previous result still waits on m_ready.
//
module clock_mult_shift_calc
    import cms_pkg::*;
#(
    parameter int unsigned START_SHIFT = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cms_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cms_out_t m_data
);

    localparam logic [ShiftW-1:0] ShInit = ShiftW'(START_SHIFT);
    localparam logic [CntW-1:0]   CntLast = CntW'(DvdW - 1);
    localparam logic [ShiftW-1:0] RoomInit = ShiftW'(WordW);

    // Sequencer
    cms_state_t state_reg, state_next;

    // Datapath registers
    logic [WordW-1:0]  from_reg, from_next;
    logic [WordW-1:0]  to_reg, to_next;
    logic [WordW-1:0]  span_reg, span_next;
    logic [WordW-1:0]  hi_reg, hi_next;       // upper word of span*from, shifted down
    logic [ShiftW-1:0] room_reg, room_next;   // headroom bits
    logic [ShiftW-1:0] sh_reg, sh_next;       // current trial shift
    logic [DvdW-1:0]   dvd_reg, dvd_next;     // dividend in, quotient out
    logic [WordW-1:0]  rem_reg, rem_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    cms_out_t          res_reg, res_next;
    cms_out_t          m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    // Shared arithmetic
    logic [DvdW-1:0]  prod;
    logic [DvdW-1:0]  dvd_load;
    logic [WordW:0]   rem_shift;
    logic [WordW:0]   rem_diff;
    logic             q_bit;
    logic [DvdW-1:0]  low_mask;
    logic             fits;
    logic             out_free;

    assign prod      = DvdW'(span_reg) * DvdW'(from_reg);
    assign dvd_load  = (DvdW'(to_reg) << sh_reg) + DvdW'(from_reg >> 1);
    assign rem_shift = {rem_reg, dvd_reg[DvdW-1]};
    assign rem_diff  = rem_shift - {1'b0, from_reg};
    assign q_bit     = ~rem_diff[WordW];
    assign low_mask  = (DvdW'(1) << room_reg) - DvdW'(1);
    assign fits      = ((dvd_reg & ~low_mask) == '0);
    assign out_free  = ~m_valid_reg | m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.from_hz == '0) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ROOM;
            ST_ROOM: begin
                if (hi_reg == '0 || room_reg == '0) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CntLast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // stop at the first fitting quotient, or after shift 1
                state_next = (fits || sh_reg == ShiftW'(1)) ? ST_OUT : ST_LOAD;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        from_next    = from_reg;
        to_next      = to_reg;
        span_next    = span_reg;
        hi_next      = hi_reg;
        room_next    = room_reg;
        sh_next      = sh_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        case (state_reg)
            ST_IDLE: begin
                from_next = s_data.from_hz;
                to_next   = s_data.to_hz;
                span_next = s_data.max_seconds;
                // zero source frequency: flagged, outputs zero
                res_next.mult      = '0;
                res_next.shift     = '0;
                res_next.bad_input = 1'b1;
            end
            ST_MUL: begin
                hi_next   = prod[DvdW-1:WordW];
                room_next = RoomInit;
                sh_next   = ShInit;
            end
            ST_ROOM: begin
                if (hi_reg != '0 && room_reg != '0) begin
                    hi_next   = hi_reg >> 1;
                    room_next = room_reg - ShiftW'(1);
                end
            end
            ST_LOAD: begin
                dvd_next = dvd_load;
                rem_next = '0;
                cnt_next = '0;
            end
            ST_DIV: begin
                // one restoring step: quotient bit enters at the bottom
                rem_next = q_bit ? rem_diff[WordW-1:0] : rem_shift[WordW-1:0];
                dvd_next = {dvd_reg[DvdW-2:0], q_bit};
                cnt_next = cnt_reg + CntW'(1);
            end
            ST_CHECK: begin
                res_next.mult      = dvd_reg[WordW-1:0];
                res_next.shift     = fits ? sh_reg : '0;
                res_next.bad_input = 1'b0;
                if (!fits) begin
                    sh_next = sh_reg - ShiftW'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg & ~m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        from_reg   <= from_next;
        to_reg     <= to_next;
        span_reg   <= span_next;
        hi_reg     <= hi_next;
        room_reg   <= room_next;
        sh_reg     <= sh_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
